// ===== rtl/range_bitmap_tracker_assert.svh =====
// assertion macros shared by the range bitmap tracker rtl
`ifndef RANGE_BITMAP_TRACKER_ASSERT_SVH
`define RANGE_BITMAP_TRACKER_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define RBT_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define RBT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/rbt_pkg.sv =====
// package with widths, command codes and shared types of the range bitmap tracker
`timescale 1ns / 1ps

package rbt_pkg;

	localparam int DOMAIN_SIZE_DEF = 1024;
	localparam int WORD_WIDTH_DEF  = 64;

	localparam int CMD_W   = 2;
	localparam int START_W = 10;
	localparam int END_W   = 11;

	localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

	// memory port control from the sequencer
	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} mem_ctl_t;

endpackage

// ===== rtl/rbt_bitmap_ram.sv =====
// single-port-write, single-port-read bitmap memory with registered read data
`timescale 1ns / 1ps

module rbt_bitmap_ram
	import rbt_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int WIDTH = 64,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  mem_ctl_t         ctl,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/rbt_word_mask.sv =====
// range mask for one bitmap word, with set/clear update and query miss flag
`timescale 1ns / 1ps

module rbt_word_mask
	import rbt_pkg::*;
#(
	parameter int WORD_WIDTH = 64,
	parameter int BASE_W     = 10
) (
	input  logic [WORD_WIDTH-1:0] rd_word,
	input  logic [BASE_W-1:0]     base,
	input  logic [START_W-1:0]    lo,
	input  logic [END_W-1:0]      hi,
	input  logic                  set_bits,
	output logic [WORD_WIDTH-1:0] new_word,
	output logic                  miss
);

	localparam int OFF_W = ((BASE_W > END_W) ? BASE_W : END_W) + 2;

	logic signed [OFF_W-1:0] lo_off;
	logic signed [OFF_W-1:0] hi_off;
	logic [WORD_WIDTH-1:0]   mask;

	// range bounds relative to the first position of this word
	assign lo_off = $signed(OFF_W'(lo)) - $signed(OFF_W'(base));
	assign hi_off = $signed(OFF_W'(hi)) - $signed(OFF_W'(base));

	always_comb begin
		for (int i = 0; i < WORD_WIDTH; i++) begin
			mask[i] = (lo_off <= $signed(OFF_W'(i))) && ($signed(OFF_W'(i)) < hi_off);
		end
	end

	assign new_word = set_bits ? (rd_word | mask) : (rd_word & ~mask);
	assign miss     = |(mask & ~rd_word);

endmodule

// ===== rtl/rbt_ctrl.sv =====
// sequencer: clearing pass, word walk from word 0 to the end of the range and result strobe
`timescale 1ns / 1ps
`include "range_bitmap_tracker_assert.svh"

module rbt_ctrl
	import rbt_pkg::*;
#(
	parameter int DOMAIN_SIZE = 1024,
	parameter int WORD_WIDTH  = 64,
	parameter int NUM_WORDS   = 16,
	parameter int AW          = 4,
	parameter int BASE_W      = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [CMD_W-1:0]      cmd,
	input  logic [START_W-1:0]    range_start,
	input  logic [END_W-1:0]      range_end,
	output mem_ctl_t              mem_ctl,
	output logic [AW-1:0]         rd_addr,
	output logic [AW-1:0]         wr_addr,
	output logic [WORD_WIDTH-1:0] wr_data,
	output logic [BASE_W-1:0]     base_s1,
	output logic [START_W-1:0]    lo_q,
	output logic [END_W-1:0]      hi_q,
	output logic                  set_bits,
	input  logic [WORD_WIDTH-1:0] new_word,
	input  logic                  miss,
	output logic                  done,
	output logic                  all_tracked
);

	localparam int LIM_W = BASE_W + 1;
	localparam int CMP_W = (LIM_W > END_W) ? LIM_W : END_W;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_FINISH
	} state_t;

	state_t             state_q;
	logic [AW-1:0]      word_q;
	logic [BASE_W-1:0]  base_q;
	logic [AW-1:0]      addr_s1;
	logic               v_s1;
	logic [CMD_W-1:0]   cmd_q;
	logic               ok_q;

	logic [END_W-1:0]   hi_clamp;
	logic               empty;
	logic               accept;
	logic               last_read;
	logic               is_write;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	assign hi_clamp = (32'(range_end) > DOMAIN_SIZE) ? END_W'(DOMAIN_SIZE) : range_end;
	assign empty    = ({1'b0, range_start} >= hi_clamp);

	// the word at base_q is the last one that the range touches
	assign last_read = (CMP_W'(base_q) + CMP_W'(WORD_WIDTH)) >= CMP_W'(hi_q);

	assign is_write = (cmd_q == CMD_ADD) || (cmd_q == CMD_REMOVE);
	assign set_bits = (cmd_q == CMD_ADD);

	assign mem_ctl.rd_en = (state_q == ST_READ);
	assign mem_ctl.wr_en = (state_q == ST_CLEAR) || (v_s1 && is_write);
	assign rd_addr       = word_q;
	assign wr_addr       = (state_q == ST_CLEAR) ? word_q : addr_s1;
	assign wr_data       = (state_q == ST_CLEAR) ? '0 : new_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			word_q      <= '0;
			base_q      <= '0;
			addr_s1     <= '0;
			base_s1     <= '0;
			v_s1        <= 1'b0;
			cmd_q       <= CMD_ADD;
			lo_q        <= '0;
			hi_q        <= '0;
			ok_q        <= 1'b0;
			done        <= 1'b0;
			all_tracked <= 1'b0;
		end else begin
			done <= 1'b0;
			v_s1 <= (state_q == ST_READ);
			if (state_q == ST_READ) begin
				addr_s1 <= word_q;
				base_s1 <= base_q;
			end
			if (v_s1 && (cmd_q == CMD_QUERY) && miss) begin
				ok_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					word_q <= word_q + 1'b1;
					if (word_q == AW'(NUM_WORDS - 1)) begin
						word_q  <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						cmd_q  <= cmd;
						lo_q   <= range_start;
						hi_q   <= hi_clamp;
						ok_q   <= 1'b1;
						word_q <= '0;
						base_q <= '0;
						if (empty || !((cmd == CMD_ADD) || (cmd == CMD_QUERY) ||
								(cmd == CMD_REMOVE))) begin
							done        <= 1'b1;
							all_tracked <= (cmd == CMD_QUERY) && empty;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					word_q <= word_q + 1'b1;
					base_q <= base_q + BASE_W'(WORD_WIDTH);
					if (last_read) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					state_q     <= ST_IDLE;
					done        <= 1'b1;
					all_tracked <= (cmd_q == CMD_QUERY) && ok_q && !miss;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`RBT_ASSERT_IMPLY(a_done_idle, clk, arst_n, done, !busy, "result strobe while busy")
	`RBT_ASSERT_IMPLY(a_wr_has_data, clk, arst_n, mem_ctl.wr_en && (state_q != ST_CLEAR), v_s1, "write-back without read data")
	`RBT_ASSERT_NEXT(a_accept_moves, clk, arst_n, accept, done || (state_q == ST_READ), "accepted item neither finished nor started")
	`RBT_ASSERT_NEXT(a_finish_strobe, clk, arst_n, state_q == ST_FINISH, done && !busy, "finish without result strobe")

endmodule

// ===== rtl/range_bitmap_tracker.sv =====
// top level of the range bitmap tracker: memory, word mask and sequencer
`timescale 1ns / 1ps

// range bitmap tracker
// keeps one mark bit per position of [0, DOMAIN_SIZE) in a bitmap memory of
// WORD_WIDTH-bit words. an item is taken when start is high and busy is low;
// cmd add marks [range_start, range_end), remove unmarks it, query checks that
// every position in it is marked. range_end is clamped to DOMAIN_SIZE, and an
// empty range changes nothing and queries as true. unused command codes are
// ignored and answer 0. every item gives exactly one result: done is high for
// a single cycle with all_tracked beside it, and there is no way to hold it
// off, so sample it when it comes (add and remove answer 0).
// timing: the sequencer walks the bitmap words from word 0 up to the word that
// holds the last position of the range, one masked read-modify-write per cycle
// on the memory's single read and write ports. for a non-empty range busy stays
// high until the walk and its last write-back are through, and done comes in
// the cycle that busy drops. an empty range or unused command keeps busy low
// and gives done in the next cycle. after reset a clearing pass zeroes the
// memory, one word a cycle, and busy stays high through it, so no item is
// taken before it ends.

module range_bitmap_tracker
	import rbt_pkg::*;
#(
	parameter int DOMAIN_SIZE = DOMAIN_SIZE_DEF,
	parameter int WORD_WIDTH  = WORD_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [CMD_W-1:0]   cmd,
	input  logic [START_W-1:0] range_start,
	input  logic [END_W-1:0]   range_end,
	output logic               done,
	output logic               all_tracked
);

	// words needed to cover the domain, and index and position widths
	localparam int NUM_WORDS = (DOMAIN_SIZE + WORD_WIDTH - 1) / WORD_WIDTH;
	localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int BASE_W    = $clog2(NUM_WORDS * WORD_WIDTH);

	mem_ctl_t              mem_ctl;
	logic [AW-1:0]         rd_addr;
	logic [AW-1:0]         wr_addr;
	logic [WORD_WIDTH-1:0] rd_data;
	logic [WORD_WIDTH-1:0] wr_data;
	logic [WORD_WIDTH-1:0] new_word;
	logic [BASE_W-1:0]     base_s1;
	logic [START_W-1:0]    lo_q;
	logic [END_W-1:0]      hi_q;
	logic                  set_bits;
	logic                  miss;

	// bitmap store, with read data registered from the read address
	rbt_bitmap_ram #(
		.DEPTH (NUM_WORDS),
		.WIDTH (WORD_WIDTH),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.ctl     (mem_ctl),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	// masks the returned word against the range and forms the write-back
	rbt_word_mask #(
		.WORD_WIDTH (WORD_WIDTH),
		.BASE_W     (BASE_W)
	) u_mask (
		.rd_word  (rd_data),
		.base     (base_s1),
		.lo       (lo_q),
		.hi       (hi_q),
		.set_bits (set_bits),
		.new_word (new_word),
		.miss     (miss)
	);

	// item handshake, word walk, clearing pass and result strobe
	rbt_ctrl #(
		.DOMAIN_SIZE (DOMAIN_SIZE),
		.WORD_WIDTH  (WORD_WIDTH),
		.NUM_WORDS   (NUM_WORDS),
		.AW          (AW),
		.BASE_W      (BASE_W)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.cmd         (cmd),
		.range_start (range_start),
		.range_end   (range_end),
		.mem_ctl     (mem_ctl),
		.rd_addr     (rd_addr),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.base_s1     (base_s1),
		.lo_q        (lo_q),
		.hi_q        (hi_q),
		.set_bits    (set_bits),
		.new_word    (new_word),
		.miss        (miss),
		.done        (done),
		.all_tracked (all_tracked)
	);

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for the range bitmap tracker: directed and random items over idle phases
`timescale 1ns / 1ps

module tb_top;
	import rbt_pkg::*;

	// the block leaves code 3 unused, and it must be ignored
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int DOMAIN = DOMAIN_SIZE_DEF;
	localparam int RANDOM_PER_PHASE = 295;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [CMD_W-1:0]   op;
		logic [START_W-1:0] lo;
		logic [END_W-1:0]   hi;
	} range_item_t;

	// clock and reset
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// block inputs, known from time zero
	logic               start = 1'b0;
	logic [CMD_W-1:0]   cmd = CMD_ADD;
	logic [START_W-1:0] range_start = '0;
	logic [END_W-1:0]   range_end = '0;

	// block outputs
	logic busy;
	logic done;
	logic all_tracked;

	// items waiting to be driven, and answers waiting to come back
	range_item_t pend_q[$];
	logic        answer_q[$];
	range_item_t nxt;
	logic        took = 1'b0;
	int          idle_pct = 0;

	// model copy of the bitmap, one bit per position
	logic [DOMAIN-1:0] marks = '0;

	// tallies
	int fails = 0;
	int n_add = 0;
	int n_remove = 0;
	int n_query_true = 0;
	int n_query_false = 0;
	int n_ignored = 0;
	int n_results = 0;

	range_bitmap_tracker dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.range_start(range_start),
		.range_end  (range_end),
		.done       (done),
		.all_tracked(all_tracked)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// applies one item to the model bitmap and gives the answer the block owes
	function automatic logic apply_range_cmd(logic [CMD_W-1:0] op, logic [START_W-1:0] lo,
			logic [END_W-1:0] hi);
		int last;
		logic verdict;
		// the end is clamped to the domain; an empty range leaves the loops idle
		last = (int'(hi) > DOMAIN) ? DOMAIN : int'(hi);
		verdict = 1'b0;
		case (op)
			CMD_ADD: begin
				for (int p = int'(lo); p < last; p++)
					marks[p] = 1'b1;
				n_add++;
			end
			CMD_REMOVE: begin
				for (int p = int'(lo); p < last; p++)
					marks[p] = 1'b0;
				n_remove++;
			end
			CMD_QUERY: begin
				verdict = 1'b1;
				for (int p = int'(lo); p < last; p++)
					if (!marks[p])
						verdict = 1'b0;
				if (verdict)
					n_query_true++;
				else
					n_query_false++;
			end
			default: begin
				// unused code: bitmap untouched, answer 0
				n_ignored++;
			end
		endcase
		return verdict;
	endfunction

	task automatic report_fail(string what);
		fails++;
		if (fails <= REPORT_LIMIT)
			$display("mismatch at %0t: %s", $time, what);
	endtask

	task automatic push_item(logic [CMD_W-1:0] op, int lo, int hi);
		range_item_t it;
		it.op = op;
		it.lo = START_W'(lo);
		it.hi = END_W'(hi);
		pend_q.insert(pend_q.size(), it);
	endtask

	// range length, mostly short so that the block turns items round quickly
	function automatic int pick_span();
		int sel;
		sel = $urandom_range(9);
		if (sel < 6)
			return $urandom_range(80);
		else if (sel < 9)
			return $urandom_range(400);
		return $urandom_range(1100);
	endfunction

	// a single item with no relation to what went before
	task automatic push_noise();
		int op;
		int lo;
		int hi;
		op = $urandom_range(3);
		if (op == int'(CMD_UNUSED) && $urandom_range(1) == 0)
			op = int'(CMD_QUERY);
		lo = $urandom_range(1023);
		if ($urandom_range(3) == 0)
			hi = $urandom_range(2047);
		else
			hi = lo + pick_span();
		if (hi > 2047)
			hi = 2047;
		push_item(CMD_W'(op), lo, hi);
	endtask

	// mark a range, then ask about pieces of it so that queries can come back true;
	// sometimes punch a hole in it and ask again over the whole range
	task automatic push_sequence();
		int a;
		int b;
		int e;
		int ql;
		int qh;
		int rl;
		a = $urandom_range(1023);
		b = a + pick_span();
		if (b > 2047)
			b = 2047;
		e = (b > DOMAIN) ? DOMAIN : b;
		push_item(CMD_ADD, a, b);
		repeat ($urandom_range(3, 1)) begin
			if (e > a) begin
				ql = $urandom_range(e, a);
				qh = $urandom_range(e, ql);
				if (ql > 1023)
					ql = 1023;
			end else begin
				ql = a;
				qh = b;
			end
			push_item(CMD_QUERY, ql, qh);
		end
		if (e > a && $urandom_range(9) < 3) begin
			rl = $urandom_range(e - 1, a);
			push_item(CMD_REMOVE, rl, rl + 1 + $urandom_range(3));
			push_item(CMD_QUERY, a, e);
		end
	endtask

	// hold the sender off until every item is taken and every answer is back
	task automatic drain();
		while (pend_q.size() != 0 || start || answer_q.size() != 0)
			@(posedge clk);
	endtask

	// driver: offers the next item at the falling edge once the last one was taken
	always @(negedge clk) begin
		if (arst_n) begin
			if (!start || took) begin
				if (pend_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
					nxt = pend_q.pop_front();
					cmd <= nxt.op;
					range_start <= nxt.lo;
					range_end <= nxt.hi;
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: checks answers in order, then records what an accepted item owes
	always @(posedge clk) begin
		if (arst_n) begin
			// an answer seen at this edge always belongs to an item taken earlier
			if (done) begin
				n_results++;
				if (answer_q.size() == 0) begin
					report_fail($sformatf("answer %b with nothing outstanding", all_tracked));
				end else if (all_tracked !== answer_q[0]) begin
					report_fail($sformatf("all_tracked expected %b, got %b",
						answer_q[0], all_tracked));
					void'(answer_q.pop_front());
				end else begin
					void'(answer_q.pop_front());
				end
			end
			if (start && !busy)
				answer_q.insert(answer_q.size(), apply_range_cmd(cmd, range_start, range_end));
			took <= start && !busy;
		end
	end

	// stimulus and verdict
	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part: whole domain, clamping, word edges, empty ranges, unused code
		push_item(CMD_QUERY, 0, 1024);     // nothing marked yet
		push_item(CMD_ADD, 0, 1024);       // whole domain
		push_item(CMD_QUERY, 0, 2047);     // end far past the domain, clamped
		push_item(CMD_REMOVE, 5, 6);       // one position
		push_item(CMD_QUERY, 0, 1024);
		push_item(CMD_QUERY, 0, 5);
		push_item(CMD_QUERY, 6, 1024);
		push_item(CMD_QUERY, 5, 6);
		push_item(CMD_QUERY, 10, 10);      // empty range answers true
		push_item(CMD_QUERY, 1023, 3);     // reversed range is empty too
		push_item(CMD_UNUSED, 0, 1024);    // ignored, answers 0
		push_item(CMD_QUERY, 0, 5);        // unused code left bitmap alone
		push_item(CMD_REMOVE, 0, 2047);
		push_item(CMD_QUERY, 1023, 1024);
		push_item(CMD_ADD, 1023, 2047);    // last position only
		push_item(CMD_QUERY, 1023, 1500);
		push_item(CMD_ADD, 63, 65);        // across a word boundary
		push_item(CMD_QUERY, 63, 65);
		push_item(CMD_QUERY, 62, 65);
		push_item(CMD_REMOVE, 100, 50);    // empty remove changes nothing
		push_item(CMD_ADD, 900, 900);      // empty add changes nothing
		push_item(CMD_QUERY, 63, 65);
		push_item(CMD_QUERY, 899, 901);
		push_item(CMD_UNUSED, 1023, 0);
		drain();

		// random phases; the receiver cannot stall, so only the sender gap varies
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: idle_pct = 0;
				1: idle_pct = 67;
				2: idle_pct = 0;
				default: idle_pct = 12;
			endcase
			begin
				int target;
				target = RANDOM_PER_PHASE;
				while (target > 0) begin
					if ($urandom_range(9) < 7) begin
						target -= 3;
						push_sequence();
					end else begin
						target -= 1;
						push_noise();
					end
				end
			end
			drain();
		end

		// the last answer is in; give any stray strobe time to show up
		repeat (40) @(posedge clk);
		if (answer_q.size() != 0)
			report_fail($sformatf("%0d answers never came", answer_q.size()));

		$display("run covered %0d answers: %0d adds, %0d removes, %0d ignored codes",
			n_results, n_add, n_remove, n_ignored);
		$display("queries: %0d fully marked, %0d not, over four sender gap phases; %0d failures",
			n_query_true, n_query_false, fails);
		if (fails == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rbt_pkg.sv
rtl/rbt_bitmap_ram.sv
rtl/rbt_word_mask.sv
rtl/rbt_ctrl.sv
rtl/range_bitmap_tracker.sv
tb/tb_top.sv
